[rtl/isort_pkg.sv]
// Package for the insertion sort engine: controller states, the command and
// status structs between controller and datapath, and the register indexes.
// No dependencies.
package isort_pkg;

   localparam int KEY_W      = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ASCENDING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_KEYS = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_DONE,
      ST_OUT_READ,
      ST_OUT_HOLD
   } isort_state_type;

   typedef struct packed {
      logic load_key;   // capture the accepted key and start position
      logic rd_scan;    // read the entry below the insert position
      logic shift;      // move the read entry up one slot
      logic place;      // write the key at the insert position
      logic out_start;  // reset the readout index
      logic out_rd;     // read the entry at the readout index
      logic out_next;   // advance the readout index
      logic clear_fill; // empty the list after the last beat
   } isort_cmd_type;

   typedef struct packed {
      logic full;
      logic pos_zero;
      logic move;
      logic final_key;
      logic fill_zero;
      logic out_last;
   } isort_status_type;

endpackage

[rtl/isort_ctrl.sv]
// Controller state machine of the insertion sort engine.
// Depends on isort_pkg for the state enum and the command/status structs.
module isort_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  isort_pkg::isort_status_type status,
   output isort_pkg::isort_cmd_type    cmd
);
   import isort_pkg::*;

   isort_state_type state_ff;
   isort_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_key = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (status.full) begin
               state_in = ST_DONE;
            end else if (status.pos_zero) begin
               cmd.place = 1'b1;
               state_in  = ST_DONE;
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = ST_CMP;
            end
         end
         ST_CMP: begin
            if (status.move) begin
               cmd.shift = 1'b1;
               state_in  = ST_SCAN;
            end else begin
               cmd.place = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.final_key && !status.fill_zero) begin
               cmd.out_start = 1'b1;
               state_in      = ST_OUT_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT_READ: begin
            cmd.out_rd = 1'b1;
            state_in   = ST_OUT_HOLD;
         end
         ST_OUT_HOLD: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (status.out_last) begin
                  cmd.clear_fill = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = ST_OUT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A beat is only offered after its entry has been read out of the store.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_HOLD) |-> $past(cmd.out_rd) || $past(state_ff == ST_OUT_HOLD))
      else $error("response offered without a store read");

   // A stalled response keeps the machine waiting.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // Input is never taken while a readout is in progress.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_READ || state_ff == ST_OUT_HOLD) |-> !req_tready)
      else $error("input accepted during readout");

endmodule

[rtl/isort_datapath.sv]
// Datapath of the insertion sort engine: key store memory, fill count,
// insert position, readout index and the configuration registers.
// Depends on isort_pkg for the command/status structs and register indexes.
module isort_datapath #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [isort_pkg::KEY_W-1:0]          req_key,
   input  logic                                req_final,
   input  logic                                csr_write,
   input  logic [isort_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [isort_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  isort_pkg::isort_cmd_type             cmd,
   output isort_pkg::isort_status_type          status,
   output logic [isort_pkg::KEY_W-1:0]          rsp_key,
   output logic                                rsp_last
);
   import isort_pkg::*;

   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   logic signed [KEY_W-1:0] mem [MAX_ELEMENTS];
   logic signed [KEY_W-1:0] rd_data_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic                    final_ff;
   logic [CW-1:0]           pos_ff;
   logic [CW-1:0]           fill_ff;
   logic [AW-1:0]           out_idx_ff;
   logic                    asc_ff;
   logic                    byte_ff;

   logic signed [KEY_W-1:0] key_in;
   logic [CW-1:0]           pos_dec;
   logic [AW-1:0]           rd_addr;
   logic                    rd_en;
   logic                    wr_en;
   logic signed [KEY_W-1:0] wr_data;

   assign key_in  = byte_ff ? {{(KEY_W-8){req_key[7]}}, req_key[7:0]} : req_key;
   assign pos_dec = pos_ff - CW'(1);
   assign rd_en   = cmd.rd_scan | cmd.out_rd;
   assign rd_addr = cmd.rd_scan ? pos_dec[AW-1:0] : out_idx_ff;
   assign wr_en   = cmd.shift | cmd.place;
   assign wr_data = cmd.shift ? rd_data_ff : key_ff;

   // Key store: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff   <= key_in;
         final_ff <= req_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         fill_ff    <= '0;
         out_idx_ff <= '0;
         asc_ff     <= 1'b1;
         byte_ff    <= 1'b0;
      end else begin
         if (cmd.load_key) begin
            pos_ff <= fill_ff;
         end else if (cmd.shift) begin
            pos_ff <= pos_dec;
         end
         if (cmd.place) begin
            fill_ff <= fill_ff + CW'(1);
         end else if (cmd.clear_fill) begin
            fill_ff <= '0;
         end
         if (cmd.out_start) begin
            out_idx_ff <= '0;
         end else if (cmd.out_next) begin
            out_idx_ff <= out_idx_ff + AW'(1);
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_ASCENDING: asc_ff  <= csr_wdata[0];
               CSR_BYTE_KEYS: byte_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // An entry moves up only on strict inequality, which keeps equal keys stable.
   always_comb begin
      status.full      = (fill_ff == CW'(MAX_ELEMENTS));
      status.pos_zero  = (pos_ff == '0);
      status.move      = asc_ff ? (rd_data_ff > key_ff) : (rd_data_ff < key_ff);
      status.final_key = final_ff;
      status.fill_zero = (fill_ff == '0);
      status.out_last  = ((CW'(out_idx_ff) + CW'(1)) == fill_ff);
   end

   assign rsp_key  = rd_data_ff;
   assign rsp_last = status.out_last;

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_ELEMENTS))
      else $error("fill count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.shift || cmd.rd_scan) |-> (pos_ff != '0))
      else $error("shift below the bottom of the store");

   assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> !status.full)
      else $error("key placed into a full store");

   assert property (@(posedge clock) disable iff (reset)
      cmd.out_rd |-> (CW'(out_idx_ff) < fill_ff))
      else $error("readout beyond the stored entries");

endmodule

[rtl/insertion_sort_engine.sv]
// Top level of the insertion sort engine: streaming key input, sorted readout.
// Depends on isort_pkg, isort_ctrl and isort_datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  req     | in        | req_tvalid/req_tready | tdata = key_value, tlast = final_item
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata = sorted_key, tlast = run_end
//  csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// A key beat moves past each stored entry that sorts after it and is then written
// at its insert position, which is the bottom of the store when it moves past
// every stored entry; the store has one write and one registered read port, and
// each move is a read followed by a compare-and-write. A key that finds the store
// full is dropped. A final beat then reads the list out, one store read per
// result beat, each held through any rsp_tready stall. Reset is synchronous and
// active high; it empties the list and sets ascending order with full keys.
// No clearing pass is needed. The input is stalled until a readout is done.
module insertion_sort_engine #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata fields from bit 0: key_value[31:0]
   input  logic [isort_pkg::KEY_W-1:0]          req_tdata,
   input  logic                                req_tlast,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata fields from bit 0: sorted_key[31:0]
   output logic [isort_pkg::KEY_W-1:0]          rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [isort_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [isort_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import isort_pkg::*;

   isort_cmd_type    cmd;
   isort_status_type status;

   // Register writes are taken in any cycle; issue them only while idle, unenforced.
   assign csr_ready = 1'b1;

   isort_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   isort_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_key   (req_tdata),
      .req_final (req_tlast),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_key   (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule
